FILE: hdl/lemc_pkg.sv
package lemc_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_ON   = 2'd2,
    CMD_OFF  = 2'd3
  } cmd_t;

  // Mode codes, as carried on new_mode and current_mode
  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_BLINK   = 3'd1;
  localparam logic [2:0] MODE_RANDOM  = 3'd2;
  localparam logic [2:0] MODE_FLICKER = 3'd3;
  localparam logic [2:0] MODE_WELDING = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_ON_TIME     = 3'd0;
  localparam logic [2:0] REG_OFF_TIME    = 3'd1;
  localparam logic [2:0] REG_RANDOM_MIN  = 3'd2;
  localparam logic [2:0] REG_RANDOM_MAX  = 3'd3;
  localparam logic [2:0] REG_COS_MODE    = 3'd4;
  localparam logic [2:0] REG_FLICK_TIME  = 3'd5;
  localparam logic [2:0] REG_FLICK_INT   = 3'd6;
  localparam logic [2:0] REG_WELD_DUTY   = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] ON_TIME_RST    = 16'd500;
  localparam logic [15:0] OFF_TIME_RST   = 16'd500;
  localparam logic [15:0] RANDOM_MIN_RST = 16'd100;
  localparam logic [15:0] RANDOM_MAX_RST = 16'd1000;
  localparam logic [15:0] FLICK_TIME_RST = 16'd100;
  localparam logic [7:0]  FLICK_INT_RST  = 8'd100;
  localparam logic [15:0] WELD_DUTY_RST  = 16'd1000;

  // Effect constants
  localparam int STATE_SPAN     = 100;  // span of the random state draw
  localparam int STATE_THRESH   = 50;   // draw at or below turns on
  localparam int LEVEL_LO       = 50;   // base flicker level
  localparam int WELD_LEVEL_HI  = 70;   // welding level upper base
  localparam int LEVEL_MAX      = 255;
  localparam int GLOW_THRESH    = 100;
  localparam int GLOW_CAP       = 200;
  localparam int GLOW_FAST_STEP = 3;
  localparam int WELD_MIN       = 20;
  localparam int FLICK_STEP_MIN = 10;

  localparam int DUTY_FACTOR_DEF = 4;
  localparam int SCALED_W        = 20;  // 16-bit draw times a factor up to 15

  // Deadline: now plus span, saturating at all ones
  function automatic logic [31:0] later(input logic [31:0] now,
                                        input logic [SCALED_W-1:0] span);
    logic [32:0] sum;
    sum = {1'b0, now} + 33'(span);
    return sum[32] ? '1 : sum[31:0];
  endfunction

endpackage

FILE: hdl/lemc_in_if.sv
interface lemc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  new_mode;
  logic [15:0] rand_a;
  logic [15:0] rand_b;
  logic [15:0] rand_c;

  modport source (output valid, command, new_mode, rand_a, rand_b, rand_c,
                  input ready);
  modport sink (input valid, command, new_mode, rand_a, rand_b, rand_c,
                output ready);
endinterface

FILE: hdl/lemc_out_if.sv
interface lemc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] main_level;
  logic [7:0] afterglow_level;
  logic       led_state;
  logic [2:0] current_mode;

  modport source (output valid, main_level, afterglow_level, led_state, current_mode,
                  input ready);
  modport sink (input valid, main_level, afterglow_level, led_state, current_mode,
                output ready);
endinterface

FILE: hdl/led_effect_mode_controller_core.sv
// Channel  Dir  Moves                         Handshake
// req      in   command, new_mode, rand_a/b/c valid/ready, taken when both high
// rsp      out  main/afterglow level, state,  valid/ready, one per request
//               current mode
// cfg      in   register index and data       cfg_write, no wait
//
// Between one acceptance and the next, a request passes through the idle state that
// takes it, a plan state, two remainder passes through the shared restoring
// divider, a sum state, an update state and a state that loads the result
// register once it is free.
// The result register holds a finished result until taken; the next request
// is accepted meanwhile, and its own result waits only if the first is unread.
// Reset (rst, synchronous) restores the register defaults and the idle state.
module led_effect_mode_controller_core #(
  parameter int DUTY_FACTOR = lemc_pkg::DUTY_FACTOR_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lemc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lemc_pkg::CFG_DATA_W-1:0] cfg_data,
  lemc_in_if.sink                         req,
  lemc_out_if.source                      rsp
);

  localparam int SW = lemc_pkg::SCALED_W;
  localparam logic [SW-1:0] DUTY_W = SW'(DUTY_FACTOR);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PLAN  = 6'b000010,
    S_DIV   = 6'b000100,
    S_SUM   = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] on_time, off_time, random_min, random_max;
  logic        random_cos_mode;
  logic [15:0] flicker_time, welding_duty;
  logic [7:0]  flicker_intensity;

  // Effect state
  logic [31:0] time_now, next_step_time, next_duty_time;
  logic [2:0]  active_mode;
  logic        on_flag, welding_active;
  logic [7:0]  glow_decay, main_drive, glow_drive;

  // Held request
  lemc_pkg::cmd_t held_cmd;
  logic [2:0]     held_mode;
  logic [15:0]    held_a, held_b, held_c;

  // Draw slots
  logic [15:0]   lo0, lo1, span0, span1, word1, rem0;
  logic          deg0, deg1;
  logic [15:0]   v0, v1;
  logic [SW-1:0] duty_scaled;

  // Divider
  logic [15:0] div_rem, div_word;
  logic [3:0]  div_cnt;
  logic        div_slot;

  // Output register
  logic        out_valid;
  logic [7:0]  out_main, out_glow;
  logic        out_state;
  logic [2:0]  out_mode;

  // Choose draw operands for both slots
  logic [15:0] p_lo0, p_lo1, p_w0, p_w1;
  logic [16:0] p_hi0, p_hi1;

  always_comb begin
    p_lo0 = '0;
    p_hi0 = '0;
    p_w0  = '0;
    p_lo1 = '0;
    p_hi1 = '0;
    p_w1  = '0;
    unique case (held_cmd)
      lemc_pkg::CMD_TICK: begin
        case (active_mode)
          lemc_pkg::MODE_RANDOM: begin
            p_hi0 = 17'(lemc_pkg::STATE_SPAN);
            p_w0  = held_a;
            p_lo1 = random_min;
            p_hi1 = {1'b0, random_max};
            p_w1  = held_b;
          end
          lemc_pkg::MODE_FLICKER: begin
            p_lo0 = 16'(lemc_pkg::LEVEL_LO);
            p_hi0 = 17'(lemc_pkg::LEVEL_LO) + 17'(flicker_intensity);
            p_w0  = held_a;
            p_lo1 = 16'(lemc_pkg::FLICK_STEP_MIN);
            p_hi1 = {1'b0, flicker_time};
            p_w1  = held_b;
          end
          lemc_pkg::MODE_WELDING: begin
            if (welding_active) begin
              p_lo0 = 16'(lemc_pkg::LEVEL_LO);
              p_hi0 = 17'(lemc_pkg::WELD_LEVEL_HI) + 17'(flicker_intensity);
              p_w0  = held_a;
            end else begin
              p_lo0 = 16'(lemc_pkg::WELD_MIN);
              p_hi0 = {1'b0, flicker_time};
              p_w0  = held_b;
            end
            p_lo1 = 16'(lemc_pkg::WELD_MIN);
            p_hi1 = {1'b0, welding_duty};
            p_w1  = held_c;
          end
          default: ;
        endcase
      end
      lemc_pkg::CMD_SET: begin
        case (held_mode)
          lemc_pkg::MODE_RANDOM: begin
            p_lo1 = random_min;
            p_hi1 = {1'b0, random_max};
            p_w1  = held_b;
          end
          lemc_pkg::MODE_FLICKER: begin
            p_hi1 = {1'b0, flicker_time};
            p_w1  = held_b;
          end
          lemc_pkg::MODE_WELDING: begin
            p_hi0 = {1'b0, flicker_time};
            p_w0  = held_b;
            p_lo1 = 16'(lemc_pkg::WELD_MIN);
            p_hi1 = {1'b0, welding_duty};
            p_w1  = held_c;
          end
          default: ;
        endcase
      end
      lemc_pkg::CMD_ON, lemc_pkg::CMD_OFF: ;
    endcase
  end

  // Shared restoring remainder step, one dividend bit per cycle
  logic [15:0] cur_span;
  logic        cur_deg;
  logic [16:0] div_shift;
  logic        div_fit;
  logic [15:0] div_rem_next;

  always_comb begin
    cur_span     = div_slot ? span1 : span0;
    cur_deg      = div_slot ? deg1 : deg0;
    div_shift    = {div_rem, div_word[15]};
    div_fit      = div_shift >= {1'b0, cur_span};
    div_rem_next = div_fit ? 16'(div_shift - {1'b0, cur_span}) : div_shift[15:0];
  end

  logic [15:0] v0_sum, v1_sum;
  assign v0_sum = lo0 + (deg0 ? 16'd0 : rem0);
  assign v1_sum = lo1 + (deg1 ? 16'd0 : div_rem);

  // Effect update from the two draws
  logic [31:0] step_time_next, duty_time_next;
  logic [2:0]  active_mode_next;
  logic        on_flag_next, welding_active_next;
  logic [7:0]  glow_decay_next, main_drive_next, glow_drive_next;
  logic        step_due, duty_due;
  logic [7:0]  lvl;
  logic [8:0]  glow_sum;

  always_comb begin
    step_time_next      = next_step_time;
    duty_time_next      = next_duty_time;
    active_mode_next    = active_mode;
    on_flag_next        = on_flag;
    welding_active_next = welding_active;
    glow_decay_next     = glow_decay;
    main_drive_next     = main_drive;
    glow_drive_next     = glow_drive;
    step_due = time_now >= next_step_time;
    duty_due = time_now >= next_duty_time;
    lvl      = (v0 >= 16'(lemc_pkg::LEVEL_MAX)) ? 8'(lemc_pkg::LEVEL_MAX) : v0[7:0];
    glow_sum = 9'(glow_decay) + 9'(lvl >= 8'(lemc_pkg::GLOW_THRESH));
    unique case (held_cmd)
      lemc_pkg::CMD_TICK: begin
        case (active_mode)
          lemc_pkg::MODE_BLINK: begin
            if (step_due) begin
              on_flag_next   = ~on_flag;
              step_time_next = lemc_pkg::later(time_now,
                                 SW'(on_flag_next ? on_time : off_time));
            end
          end
          lemc_pkg::MODE_RANDOM: begin
            if (step_due) begin
              on_flag_next   = random_cos_mode ? (v0 <= 16'(lemc_pkg::STATE_THRESH))
                                               : ~on_flag;
              step_time_next = lemc_pkg::later(time_now, SW'(v1));
            end
          end
          lemc_pkg::MODE_FLICKER: begin
            if (step_due) begin
              main_drive_next = lvl;
              step_time_next  = lemc_pkg::later(time_now, SW'(v1));
            end
          end
          lemc_pkg::MODE_WELDING: begin
            if (step_due) begin
              // Burst: random level, build up the afterglow
              if (welding_active) begin
                main_drive_next = lvl;
                glow_decay_next = (glow_sum >= 9'(lemc_pkg::GLOW_CAP))
                                  ? 8'(lemc_pkg::GLOW_CAP) : glow_sum[7:0];
                glow_drive_next = glow_decay_next >> 1;
              end else begin
                // Pause: dark main, decay the afterglow
                main_drive_next = '0;
                if (glow_decay >= 8'(lemc_pkg::GLOW_THRESH)) begin
                  glow_decay_next = glow_decay - 8'(lemc_pkg::GLOW_FAST_STEP);
                  glow_drive_next = glow_decay_next;
                end else begin
                  glow_drive_next = glow_decay;
                  if (glow_decay != 8'd0) glow_decay_next = glow_decay - 8'd1;
                end
                if (glow_decay_next <= 8'(lemc_pkg::GLOW_FAST_STEP)) glow_drive_next = '0;
                step_time_next = lemc_pkg::later(time_now, SW'(v0));
              end
              if (duty_due) begin
                welding_active_next = ~welding_active;
                duty_time_next = lemc_pkg::later(time_now,
                                   welding_active_next ? SW'(v1) : duty_scaled);
              end
            end
          end
          default: ;
        endcase
        if (active_mode != lemc_pkg::MODE_FLICKER && active_mode != lemc_pkg::MODE_WELDING)
          main_drive_next = on_flag_next ? 8'(lemc_pkg::LEVEL_MAX) : 8'd0;
      end
      lemc_pkg::CMD_SET: begin
        if (held_mode <= lemc_pkg::MODE_WELDING) active_mode_next = held_mode;
        case (held_mode)
          lemc_pkg::MODE_NORMAL: on_flag_next = 1'b0;
          lemc_pkg::MODE_BLINK:  step_time_next = lemc_pkg::later(time_now, SW'(off_time));
          lemc_pkg::MODE_RANDOM,
          lemc_pkg::MODE_FLICKER: step_time_next = lemc_pkg::later(time_now, SW'(v1));
          lemc_pkg::MODE_WELDING: begin
            welding_active_next = 1'b0;
            step_time_next      = lemc_pkg::later(time_now, SW'(v0));
            duty_time_next      = lemc_pkg::later(time_now, SW'(v1));
          end
          default: ;
        endcase
      end
      lemc_pkg::CMD_ON: begin
        active_mode_next = lemc_pkg::MODE_NORMAL;
        on_flag_next     = 1'b1;
      end
      lemc_pkg::CMD_OFF: begin
        active_mode_next = lemc_pkg::MODE_NORMAL;
        on_flag_next     = 1'b0;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      on_time           <= lemc_pkg::ON_TIME_RST;
      off_time          <= lemc_pkg::OFF_TIME_RST;
      random_min        <= lemc_pkg::RANDOM_MIN_RST;
      random_max        <= lemc_pkg::RANDOM_MAX_RST;
      random_cos_mode   <= 1'b0;
      flicker_time      <= lemc_pkg::FLICK_TIME_RST;
      flicker_intensity <= lemc_pkg::FLICK_INT_RST;
      welding_duty      <= lemc_pkg::WELD_DUTY_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lemc_pkg::REG_ON_TIME:    on_time           <= cfg_data;
        lemc_pkg::REG_OFF_TIME:   off_time          <= cfg_data;
        lemc_pkg::REG_RANDOM_MIN: random_min        <= cfg_data;
        lemc_pkg::REG_RANDOM_MAX: random_max        <= cfg_data;
        lemc_pkg::REG_COS_MODE:   random_cos_mode   <= cfg_data[0];
        lemc_pkg::REG_FLICK_TIME: flicker_time      <= cfg_data;
        lemc_pkg::REG_FLICK_INT:  flicker_intensity <= cfg_data[7:0];
        lemc_pkg::REG_WELD_DUTY:  welding_duty      <= cfg_data;
      endcase
    end
  end

  // Load a finished result when the register is free, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and effect state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      time_now       <= '0;
      next_step_time <= '0;
      next_duty_time <= '0;
      active_mode    <= lemc_pkg::MODE_NORMAL;
      on_flag        <= 1'b0;
      welding_active <= 1'b0;
      glow_decay     <= '0;
      main_drive     <= '0;
      glow_drive     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            held_cmd  <= lemc_pkg::cmd_t'(req.command);
            held_mode <= req.new_mode;
            held_a    <= req.rand_a;
            held_b    <= req.rand_b;
            held_c    <= req.rand_c;
            state     <= S_PLAN;
          end
        end
        S_PLAN: begin
          // On a tick, advance the clock before the mode update
          if (held_cmd == lemc_pkg::CMD_TICK) time_now <= time_now + 32'd1;
          lo0      <= p_lo0;
          lo1      <= p_lo1;
          deg0     <= p_hi0 <= {1'b0, p_lo0};
          deg1     <= p_hi1 <= {1'b0, p_lo1};
          span0    <= 16'(p_hi0 - {1'b0, p_lo0});
          span1    <= 16'(p_hi1 - {1'b0, p_lo1});
          div_word <= p_w0;
          word1    <= p_w1;
          div_rem  <= '0;
          div_cnt  <= '0;
          div_slot <= 1'b0;
          state    <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15 && !div_slot) begin
            // Hold the first remainder, start the second pass
            rem0     <= div_rem_next;
            div_rem  <= '0;
            div_word <= word1;
            div_slot <= 1'b1;
          end else begin
            div_rem  <= div_rem_next;
            div_word <= div_word << 1;
            if (div_cnt == 4'd15) state <= S_SUM;
          end
        end
        S_SUM: begin
          v0          <= v0_sum;
          v1          <= v1_sum;
          duty_scaled <= SW'(v1_sum) * DUTY_W;
          state       <= S_APPLY;
        end
        S_APPLY: begin
          next_step_time <= step_time_next;
          next_duty_time <= duty_time_next;
          active_mode    <= active_mode_next;
          on_flag        <= on_flag_next;
          welding_active <= welding_active_next;
          glow_decay     <= glow_decay_next;
          main_drive     <= main_drive_next;
          glow_drive     <= glow_drive_next;
          state          <= S_DONE;
        end
        S_DONE: begin
          // Hold until the result register is free
          if (!out_valid || rsp.ready) begin
            out_main  <= main_drive;
            out_glow  <= glow_drive;
            out_state <= on_flag;
            out_mode  <= active_mode;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.main_level      = out_main;
  assign rsp.afterglow_level = out_glow;
  assign rsp.led_state       = out_state;
  assign rsp.current_mode    = out_mode;

  a_accept_plan: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_PLAN)
    else $error("accepted request did not start planning");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && !cur_deg |-> div_rem < cur_span)
    else $error("partial remainder reached the divisor");

  a_glow_cap: assert property (@(posedge clk) disable iff (rst)
    glow_decay <= 8'(lemc_pkg::GLOW_CAP))
    else $error("afterglow build-up exceeded its cap");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!out_valid || rsp.ready) |=> rsp.valid)
    else $error("finished result not presented");

endmodule
